// ===== sv/drfp_pkg.sv =====
package drfp_pkg;

    // Head and tail marker bytes
    localparam logic [7:0] CHAR_S  = 8'h53;  // 'S'
    localparam logic [7:0] CHAR_T  = 8'h54;  // 'T'
    localparam logic [7:0] CHAR_LT = 8'h3C;  // '<'
    localparam logic [7:0] CHAR_GT = 8'h3E;  // '>'
    localparam logic [7:0] CHAR_E  = 8'h45;  // 'E'

    // Result kinds
    localparam logic KIND_NAME   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // Frame status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_TAIL = 2'd1;
    localparam logic [1:0] STATUS_BAD_LEN  = 2'd2;

    localparam int unsigned DEFAULT_MAX_LENGTH = 2048;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned WORD_W = 16;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] name_byte;
        logic [WORD_W-1:0] frame_command;
        logic [BYTE_W-1:0] key_value;
        logic [1:0]        frame_status;
        logic [WORD_W-1:0] frame_crc;
    } drfp_result_t;

endpackage

// ===== sv/drfp_core.sv =====
module drfp_core #(
    parameter int unsigned MAX_LENGTH = drfp_pkg::DEFAULT_MAX_LENGTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step_en,
    input  logic [drfp_pkg::BYTE_W-1:0]  rx_byte,
    output logic                         res_valid,
    output drfp_pkg::drfp_result_t       res
);
    import drfp_pkg::*;

    localparam int unsigned COUNT_W = $clog2(MAX_LENGTH + 1);
    localparam logic [WORD_W-1:0] MAX_LEN_W = WORD_W'(MAX_LENGTH);

    typedef enum logic [3:0] {
        PH_HUNT_S, PH_HUNT_T, PH_HUNT_LT, PH_CMD_HI, PH_CMD_LO,
        PH_LEN_HI, PH_LEN_LO, PH_PAYLOAD, PH_TAIL_GT, PH_TAIL_E,
        PH_TAIL_T, PH_CRC_LO, PH_CRC_HI
    } phase_t;

    phase_t              phase_reg,   phase_next;
    logic [WORD_W-1:0]   command_reg, command_next;
    logic [WORD_W-1:0]   length_reg,  length_next;
    logic [COUNT_W-1:0]  count_reg,   count_next;
    logic [BYTE_W-1:0]   key_reg,     key_next;
    logic                tail_good_reg, tail_good_next;
    logic [BYTE_W-1:0]   crc_low_reg, crc_low_next;

    logic [WORD_W-1:0]   length_full;
    logic [COUNT_W-1:0]  count_inc;
    phase_t              restart;

    assign length_full = {length_reg[WORD_W-1:BYTE_W], rx_byte};
    assign count_inc   = count_reg + COUNT_W'(1);
    assign restart     = (rx_byte == CHAR_S) ? PH_HUNT_T : PH_HUNT_S;

    always_comb begin
        phase_next     = phase_reg;
        command_next   = command_reg;
        length_next    = length_reg;
        count_next     = count_reg;
        key_next       = key_reg;
        tail_good_next = tail_good_reg;
        crc_low_next   = crc_low_reg;
        res_valid      = 1'b0;
        res            = '0;
        res.frame_command = command_reg;

        case (phase_reg)
            PH_HUNT_T: begin
                phase_next = (rx_byte == CHAR_T) ? PH_HUNT_LT : restart;
            end
            PH_HUNT_LT: begin
                phase_next = (rx_byte == CHAR_LT) ? PH_CMD_HI : restart;
            end
            PH_CMD_HI: begin
                command_next = {rx_byte, {BYTE_W{1'b0}}};
                phase_next   = PH_CMD_LO;
            end
            PH_CMD_LO: begin
                command_next = {command_reg[WORD_W-1:BYTE_W], rx_byte};
                phase_next   = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                length_next = {rx_byte, {BYTE_W{1'b0}}};
                phase_next  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                length_next = length_full;
                if (length_full == '0 || length_full > MAX_LEN_W) begin
                    // reject the frame, report it and hunt again
                    phase_next       = PH_HUNT_S;
                    res_valid        = 1'b1;
                    res.kind         = KIND_REPORT;
                    res.frame_status = STATUS_BAD_LEN;
                end else begin
                    count_next = '0;
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                count_next = count_inc;
                if (WORD_W'(count_inc) >= length_reg) begin
                    key_next       = rx_byte;
                    tail_good_next = 1'b1;
                    phase_next     = PH_TAIL_GT;
                end else begin
                    res_valid     = 1'b1;
                    res.kind      = KIND_NAME;
                    res.name_byte = rx_byte;
                end
            end
            PH_TAIL_GT: begin
                if (rx_byte != CHAR_GT) tail_good_next = 1'b0;
                phase_next = PH_TAIL_E;
            end
            PH_TAIL_E: begin
                if (rx_byte != CHAR_E) tail_good_next = 1'b0;
                phase_next = PH_TAIL_T;
            end
            PH_TAIL_T: begin
                if (rx_byte != CHAR_T) tail_good_next = 1'b0;
                phase_next = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                crc_low_next = rx_byte;
                phase_next   = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                phase_next       = PH_HUNT_S;
                res_valid        = 1'b1;
                res.kind         = KIND_REPORT;
                res.key_value    = key_reg;
                res.frame_status = tail_good_reg ? STATUS_OK : STATUS_BAD_TAIL;
                res.frame_crc    = {rx_byte, crc_low_reg};
            end
            default: begin
                phase_next = restart;
            end
        endcase

        if (!step_en) res_valid = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HUNT_S;
            command_reg   <= '0;
            length_reg    <= '0;
            count_reg     <= '0;
            key_reg       <= '0;
            tail_good_reg <= 1'b1;
            crc_low_reg   <= '0;
        end else if (step_en) begin
            phase_reg     <= phase_next;
            command_reg   <= command_next;
            length_reg    <= length_next;
            count_reg     <= count_next;
            key_reg       <= key_next;
            tail_good_reg <= tail_good_next;
            crc_low_reg   <= crc_low_next;
        end
    end

endmodule

// ===== sv/display_reply_frame_parser_unit.sv =====
// Channel  | Ports                                  | Direction | Word
// ---------+----------------------------------------+-----------+--------------------------
// input    | s_valid, s_ready, s_rx_byte            | in        | one received serial byte
// result   | m_valid, m_ready, m_kind, m_name_byte, | out       | name byte or frame report
//          | m_frame_command, m_key_value,          |           |
//          | m_frame_status, m_frame_crc            |           |
//
// One word is accepted per cycle when the result side keeps up; the rate is set
// by the single parser step between the input register and the result register.
// An accepted word is held in the input register, and its result in the result register.
// Reset (aresetn, synchronous, active low) empties both registers and sends the
// parser back to hunting for the head.
// A stall on m_ready holds the result register and then the input register; at
// most one word waits in each, so no word is lost or repeated.
module display_reply_frame_parser_unit #(
    parameter int unsigned MAX_LENGTH = drfp_pkg::DEFAULT_MAX_LENGTH
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [drfp_pkg::BYTE_W-1:0]        s_rx_byte,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_kind,
    output logic [drfp_pkg::BYTE_W-1:0]        m_name_byte,
    output logic [drfp_pkg::WORD_W-1:0]        m_frame_command,
    output logic signed [drfp_pkg::BYTE_W-1:0] m_key_value,
    output logic [1:0]                         m_frame_status,
    output logic [drfp_pkg::WORD_W-1:0]        m_frame_crc
);
    import drfp_pkg::*;

    // Input register: one received word waiting for the parser.
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // Result register: one finished word waiting for the sink.
    logic              out_valid_reg;
    drfp_result_t      out_reg;

    logic              advance;
    logic              step;
    logic              res_valid;
    drfp_result_t      res;

    // Advance the pipe whenever the result register is free or being drained.
    assign advance = !out_valid_reg || m_ready;
    assign step    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    drfp_core #(
        .MAX_LENGTH(MAX_LENGTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    // Capture the byte on accept; no reset needed on payload.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= step && res_valid;
        end
    end

    // Load a new result only when the parser produced one this step.
    always_ff @(posedge aclk) begin
        if (step && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_kind          = out_reg.kind;
    assign m_name_byte     = out_reg.name_byte;
    assign m_frame_command = out_reg.frame_command;
    assign m_key_value     = signed'(out_reg.key_value);
    assign m_frame_status  = out_reg.frame_status;
    assign m_frame_crc     = out_reg.frame_crc;

`ifndef SYNTHESIS
    // A bad-length report carries neither key nor CRC.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_REPORT && m_frame_status == STATUS_BAD_LEN)
        |-> (m_key_value == '0 && m_frame_crc == '0))
        else $error("bad-length report carries key or crc");

    // Name bytes come out with status ok and no CRC.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_NAME)
        |-> (m_frame_status == STATUS_OK && m_frame_crc == '0))
        else $error("name byte carries report fields");

    // A waiting input word is never dropped without a parser step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !step) |=> in_valid_reg)
        else $error("input word dropped while stalled");

    // Status code three never appears.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_frame_status != 2'd3))
        else $error("invalid frame status");
`endif

endmodule
